>>> rtl/ikin_pkg.sv
// Shared types, widths and constants for the arm inverse-kinematics block.
// Holds the CORDIC arctangent table and the Q32 angle rounding function.
// No dependencies.
package ikin_pkg;

	localparam int FRAC      = 16;            // angle fraction bits
	localparam int ANGLE_W   = FRAC + 10;     // signed degrees, +-180 fits
	localparam int DIFF_W    = ANGLE_W + 1;
	localparam int COORD_W   = 14;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 8;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 64;
	localparam int YAW_W     = 19;
	localparam int INNER_W   = 22;
	localparam int OUTER_W   = 20;

	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;

	localparam int ROOT_IN_W = 64;
	localparam int ROOT_W    = 32;

	localparam int CN_W      = 34;            // CORDIC operand width
	localparam int CXY_W     = 44;            // CORDIC x/y register width
	localparam int CZ_W      = 40;            // CORDIC angle, Q32 degrees
	localparam int ZD_W      = CZ_W + 1;      // doubled / offset angle
	localparam int ITER_W    = 5;
	localparam int NORM_BIT  = 40;

	localparam logic signed [CZ_W-1:0]  Q32_90   = 40'sd386547056640;
	localparam logic signed [CXY_W-1:0] NORM_LIM = CXY_W'(1) << NORM_BIT;

	// step conversion: |diff| * 6400 / (den << FRAC), den = 9 or 3
	localparam int STEP_V_W  = 22;
	localparam int STEP_Q_W  = 20;
	localparam int RECIP_SH  = 30;
	localparam logic [12:0] STEP_NUM = 13'd6400;
	localparam logic [28:0] RECIP_9  = 29'd119304647;  // floor(2^30 / 9)
	localparam logic [28:0] RECIP_3  = 29'd357913941;  // floor(2^30 / 3)
	localparam logic [3:0]  DEN_9    = 4'd9;
	localparam logic [3:0]  DEN_3    = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINK     = 8'd0,
		CFG_OFFSET   = 8'd1,
		CFG_SHOULDER = 8'd2,
		CFG_EXTRA    = 8'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MXX, ST_MYY, ST_RSQ, ST_RSQ_W, ST_MAA, ST_MBB, ST_MUU,
		ST_CHK, ST_MQ, ST_SQQ, ST_SQQ_W, ST_MAU, ST_MBU, ST_NUM,
		ST_AT1, ST_AT1_W, ST_AT2, ST_AT2_W, ST_YAW, ST_YAW_W,
		ST_STP_MUL, ST_STP_REC, ST_STP_FIX, ST_OUT
	} ikin_state_t;

	typedef enum logic [1:0] {
		CO_IDLE, CO_NORM, CO_ITER, CO_DONE
	} cordic_state_t;

	// atan(2^-i) in degrees, 32 fraction bits
	function automatic logic signed [CZ_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
		case (i)
			5'd0:  return 40'sd193273528320;
			5'd1:  return 40'sd114096026022;
			5'd2:  return 40'sd60285206654;
			5'd3:  return 40'sd30601712202;
			5'd4:  return 40'sd15360239307;
			5'd5:  return 40'sd7687607528;
			5'd6:  return 40'sd3844741815;
			5'd7:  return 40'sd1922488225;
			5'd8:  return 40'sd961258780;
			5'd9:  return 40'sd480631223;
			5'd10: return 40'sd240315841;
			5'd11: return 40'sd120157949;
			5'd12: return 40'sd60078978;
			5'd13: return 40'sd30039489;
			5'd14: return 40'sd15019745;
			5'd15: return 40'sd7509872;
			5'd16: return 40'sd3754936;
			5'd17: return 40'sd1877468;
			5'd18: return 40'sd938734;
			5'd19: return 40'sd469367;
			5'd20: return 40'sd234684;
			5'd21: return 40'sd117342;
			5'd22: return 40'sd58671;
			5'd23: return 40'sd29335;
			5'd24: return 40'sd14668;
			5'd25: return 40'sd7334;
			5'd26: return 40'sd3667;
			5'd27: return 40'sd1833;
			5'd28: return 40'sd917;
			5'd29: return 40'sd458;
			5'd30: return 40'sd229;
			5'd31: return 40'sd115;
			default: return '0;
		endcase
	endfunction

	// Q32 degrees to FRAC bits, halves away from zero
	function automatic logic signed [ANGLE_W-1:0] round_q32(input logic signed [ZD_W-1:0] z);
		logic [ZD_W-1:0] m;
		logic [ZD_W-1:0] r;
		m = $unsigned(z[ZD_W-1] ? -z : z);
		r = (m + (ZD_W'(1) << (31 - FRAC))) >> (32 - FRAC);
		return z[ZD_W-1] ? -$signed(r[ANGLE_W-1:0]) : $signed(r[ANGLE_W-1:0]);
	endfunction

endpackage

>>> rtl/ikin_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ikin_pkg.
module ikin_mul (
	input  logic                              clk,
	input  logic signed [ikin_pkg::MUL_W-1:0]  a,
	input  logic signed [ikin_pkg::MUL_W-1:0]  b,
	output logic signed [ikin_pkg::PROD_W-1:0] p
);
	import ikin_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

>>> rtl/ikin_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on ikin_pkg.
module ikin_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ikin_pkg::ROOT_IN_W-1:0]    value,
	output logic                              done,
	output logic [ikin_pkg::ROOT_W-1:0]       root
);
	import ikin_pkg::*;

	logic [ROOT_IN_W-1:0] v_q, r_q, bit_q, trial;
	logic [5:0]           cnt_q;
	logic                 busy_q, done_q;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> rtl/ikin_cordic.sv
// Vectoring CORDIC giving atan(num/den) in Q32 degrees.
// Normalises one doubling per cycle, then 32 rotations. Depends on ikin_pkg.
module ikin_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [ikin_pkg::CN_W-1:0] num,
	input  logic signed [ikin_pkg::CN_W-1:0] den,
	output logic                             done,
	output logic signed [ikin_pkg::CZ_W-1:0] angle
);
	import ikin_pkg::*;

	cordic_state_t state_q, state_d;

	logic signed [CXY_W-1:0] x_q, y_q, xs, ys;
	logic signed [CZ_W-1:0]  z_q;
	logic [ITER_W-1:0]       i_q;
	logic signed [CN_W-1:0]  nn, dd;
	logic                    norm_stop;

	// fold a negative denominator into the numerator
	assign dd = den[CN_W-1] ? -den : den;
	assign nn = den[CN_W-1] ? -num : num;

	assign norm_stop = (y_q >= NORM_LIM) || (y_q <= -NORM_LIM) || (x_q >= NORM_LIM);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CO_IDLE: if (start) state_d = (dd == '0) ? CO_DONE : CO_NORM;
			CO_NORM: if (norm_stop) state_d = CO_ITER;
			CO_ITER: if (i_q == ITER_W'(31)) state_d = CO_DONE;
			CO_DONE: state_d = CO_IDLE;
			default: state_d = CO_IDLE;
		endcase
	end

	always_comb begin
		done  = (state_q == CO_DONE);
		angle = z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CO_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CO_IDLE: begin
				if (start) begin
					x_q <= CXY_W'(dd);
					y_q <= CXY_W'(nn);
					i_q <= '0;
					if (dd == '0) begin
						z_q <= (nn > 0) ? Q32_90 : ((nn < 0) ? -Q32_90 : '0);
					end else begin
						z_q <= '0;
					end
				end
			end
			CO_NORM: begin
				if (!norm_stop) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			CO_ITER: begin
				if (!y_q[CXY_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_entry(i_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_entry(i_q);
				end
				i_q <= i_q + ITER_W'(1);
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/arm_inverse_kinematics_steps.sv
// Inverse kinematics for a yaw-plus-two-link arm, giving stepper step counts.
// The work runs through the CORDIC unit (up to 40 normalising doublings, 32
//   rotations and a done state, run up to three times) and the square root
//   unit, run once or twice.
// s_tready is high only when idle: a new target is not taken before the last one's result word is registered.
// Reset (arst_n low, asynchronous): registers to 160/59/131/0 mm, angles 0/45/-45.
module arm_inverse_kinematics_steps (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// target_x[13:0], target_y[27:14], target_z[41:28], zero pad
	input  logic [ikin_pkg::S_DATA_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// yaw_steps[18:0], inner_steps[40:19], outer_steps[60:41], zero pad
	output logic [ikin_pkg::M_DATA_W-1:0]         m_tdata,
	// unreachable[0]
	output logic [0:0]                            m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ikin_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ikin_pkg::CFG_W-1:0]            cfg_data
);
	import ikin_pkg::*;

	ikin_state_t state_q, state_d;

	// configuration, mm
	logic [CFG_W-1:0] link_q, offset_q, shoulder_q, extra_q;

	// stored joint angles
	logic signed [ANGLE_W-1:0] yaw_now_q, inner_now_q, outer_now_q;
	logic signed [ANGLE_W-1:0] yaw_new_q, inner_new_q, outer_new_q;

	// working registers, lengths in 1/16 mm
	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic [31:0]               acc_q, s_q;
	logic [29:0]               t_q;
	logic [30:0]               q_q;
	logic signed [15:0]        a_q;
	logic signed [16:0]        b_q;
	logic [13:0]               u_q;
	logic signed [CN_W-1:0]    den_q, n1_q, n2_q;
	logic                      unr_q;
	logic [1:0]                k_q;
	logic [STEP_V_W-1:0]       v_q;
	logic signed [YAW_W-1:0]   yaw_st_q;
	logic signed [INNER_W-1:0] inner_st_q;
	logic signed [OUTER_W-1:0] outer_st_q;

	// output word register
	logic                      m_tvalid_q;
	logic [M_DATA_W-1:0]       m_tdata_q;
	logic                      m_tuser_q;

	// shared units
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      sq_start, sq_done;
	logic [ROOT_IN_W-1:0]      sq_in;
	logic [ROOT_W-1:0]         sq_root;
	logic                      co_start, co_done;
	logic signed [CN_W-1:0]    co_n, co_d;
	logic signed [CZ_W-1:0]    co_z;

	// helpers
	logic [31:0]               uu4;
	logic                      unreach;
	logic [COORD_W-1:0]        ax, ay;
	logic                      on_axis;
	logic signed [ZD_W-1:0]    yaw_zz, yaw_t;
	logic signed [CN_W-1:0]    bu2;
	logic [10:0]               he;
	logic signed [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]         mag;
	logic [3:0]                step_den;
	logic [28:0]               recip;
	logic [STEP_V_W-1:0]       v_now;
	logic [STEP_Q_W-1:0]       q0, q_fix;
	logic [23:0]               rem;
	logic signed [STEP_Q_W+2:0] sval;
	logic                      out_free;

	ikin_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ikin_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_in),
		.done   (sq_done),
		.root   (sq_root)
	);

	ikin_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (co_start),
		.num    (co_n),
		.den    (co_d),
		.done   (co_done),
		.angle  (co_z)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// reach test: S > 4U^2, product register holds U^2 in ST_CHK
	assign uu4     = {mul_p[29:0], 2'b00};
	assign unreach = s_q > uu4;

	assign ax      = $unsigned(x_q[COORD_W-1] ? -x_q : x_q);
	assign ay      = $unsigned(y_q[COORD_W-1] ? -y_q : y_q);
	assign on_axis = (x_q == '0) || (y_q == '0);
	assign he      = {1'b0, shoulder_q} + {1'b0, extra_q};

	// yaw from the quadrant: sign follows x, +90 offset when y < 0
	assign yaw_zz  = ZD_W'(co_z) + (y_q[COORD_W-1] ? ZD_W'(Q32_90) : '0);
	assign yaw_t   = x_q[COORD_W-1] ? -yaw_zz : yaw_zz;

	assign bu2     = $signed({mul_p[CN_W-2:0], 1'b0});

	// step conversion, one joint per pass (k: yaw, inner, outer)
	always_comb begin
		case (k_q)
			2'd0:    diff = DIFF_W'(yaw_new_q) - DIFF_W'(yaw_now_q);
			2'd1:    diff = DIFF_W'(inner_new_q) - DIFF_W'(inner_now_q);
			default: diff = DIFF_W'(outer_now_q) - DIFF_W'(outer_new_q);
		endcase
	end

	assign mag      = $unsigned(diff[DIFF_W-1] ? -diff : diff);
	assign step_den = (k_q == 2'd1) ? DEN_3 : DEN_9;
	assign recip    = (k_q == 2'd1) ? RECIP_3 : RECIP_9;
	assign v_now    = mul_p[FRAC+STEP_V_W-1:FRAC];
	// reciprocal estimate is low by at most one
	assign q0       = mul_p[RECIP_SH+STEP_Q_W-1:RECIP_SH];
	assign rem      = 24'(v_q) - 24'(q0) * 24'(step_den);
	assign q_fix    = (rem >= 24'(step_den)) ? q0 + STEP_Q_W'(1) : q0;
	assign sval     = diff[DIFF_W-1] ? -$signed({3'b000, q_fix}) : $signed({3'b000, q_fix});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_MXX;
			ST_MXX:     state_d = ST_MYY;
			ST_MYY:     state_d = ST_RSQ;
			ST_RSQ:     state_d = ST_RSQ_W;
			ST_RSQ_W:   if (sq_done) state_d = ST_MAA;
			ST_MAA:     state_d = ST_MBB;
			ST_MBB:     state_d = ST_MUU;
			ST_MUU:     state_d = ST_CHK;
			ST_CHK:     state_d = unreach ? ST_YAW : ST_MQ;
			ST_MQ:      state_d = ST_SQQ;
			ST_SQQ:     state_d = ST_SQQ_W;
			ST_SQQ_W:   if (sq_done) state_d = ST_MAU;
			ST_MAU:     state_d = ST_MBU;
			ST_MBU:     state_d = ST_NUM;
			ST_NUM:     state_d = ST_AT1;
			ST_AT1:     state_d = ST_AT1_W;
			ST_AT1_W:   if (co_done) state_d = ST_AT2;
			ST_AT2:     state_d = ST_AT2_W;
			ST_AT2_W:   if (co_done) state_d = ST_YAW;
			ST_YAW:     state_d = on_axis ? ST_STP_MUL : ST_YAW_W;
			ST_YAW_W:   if (co_done) state_d = ST_STP_MUL;
			ST_STP_MUL: state_d = ST_STP_REC;
			ST_STP_REC: state_d = ST_STP_FIX;
			ST_STP_FIX: state_d = (k_q == 2'd2) ? ST_OUT : ST_STP_MUL;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit operands and handshake
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		sq_in    = '0;
		co_start = 1'b0;
		co_n     = n1_q;
		co_d     = den_q;
		case (state_q)
			ST_MXX: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			ST_MYY: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(y_q);
			end
			ST_RSQ: begin
				sq_start = 1'b1;
				sq_in    = ROOT_IN_W'(acc_q) + ROOT_IN_W'(mul_p[31:0]);
			end
			ST_MAA: begin
				mul_a = MUL_W'(a_q);
				mul_b = MUL_W'(a_q);
			end
			ST_MBB: begin
				mul_a = MUL_W'(b_q);
				mul_b = MUL_W'(b_q);
			end
			ST_MUU: begin
				mul_a = MUL_W'(u_q);
				mul_b = MUL_W'(u_q);
			end
			ST_MQ: begin
				mul_a = MUL_W'(s_q);
				mul_b = MUL_W'(t_q);
			end
			ST_SQQ: begin
				sq_start = 1'b1;
				sq_in    = mul_p[ROOT_IN_W-1:0];
			end
			ST_MAU: begin
				mul_a = MUL_W'(a_q);
				mul_b = MUL_W'(u_q);
			end
			ST_MBU: begin
				mul_a = MUL_W'(b_q);
				mul_b = MUL_W'(u_q);
			end
			ST_AT1: begin
				co_start = 1'b1;
			end
			ST_AT2: begin
				co_start = 1'b1;
				co_n     = n2_q;
			end
			ST_YAW: begin
				co_start = !on_axis;
				co_n     = y_q[COORD_W-1] ? CN_W'(ay) : CN_W'(ax);
				co_d     = y_q[COORD_W-1] ? CN_W'(ax) : CN_W'(ay);
			end
			ST_STP_MUL: begin
				mul_a = MUL_W'(mag);
				mul_b = MUL_W'(STEP_NUM);
			end
			ST_STP_REC: begin
				mul_a = MUL_W'(v_now);
				mul_b = MUL_W'(recip);
			end
			default: ;
		endcase
	end

	// control, configuration and stored angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			link_q      <= CFG_W'(160);
			offset_q    <= CFG_W'(59);
			shoulder_q  <= CFG_W'(131);
			extra_q     <= CFG_W'(0);
			yaw_now_q   <= '0;
			inner_now_q <= ANGLE_W'(45) <<< FRAC;
			outer_now_q <= -(ANGLE_W'(45) <<< FRAC);
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LINK:     link_q     <= cfg_data;
					CFG_OFFSET:   offset_q   <= cfg_data;
					CFG_SHOULDER: shoulder_q <= cfg_data;
					CFG_EXTRA:    extra_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q  <= 1'b1;
				yaw_now_q   <= yaw_new_q;
				inner_now_q <= inner_new_q;
				outer_now_q <= outer_new_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					x_q         <= s_tdata[13:0];
					y_q         <= s_tdata[27:14];
					z_q         <= s_tdata[41:28];
					yaw_new_q   <= yaw_now_q;
					inner_new_q <= inner_now_q;
					outer_new_q <= outer_now_q;
					unr_q       <= 1'b0;
					k_q         <= '0;
				end
			end
			ST_MYY:   acc_q <= mul_p[31:0];
			ST_RSQ_W: begin
				if (sq_done) begin
					a_q <= $signed({1'b0, sq_root[14:0]}) - $signed({2'b00, offset_q, 4'b0000});
					b_q <= 17'(z_q) - $signed({2'b00, he, 4'b0000});
					u_q <= {link_q, 4'b0000};
				end
			end
			ST_MBB:   acc_q <= mul_p[31:0];
			ST_MUU:   s_q   <= acc_q + mul_p[31:0];
			ST_CHK: begin
				unr_q <= unreach;
				t_q   <= 30'(uu4 - s_q);
			end
			ST_SQQ_W: if (sq_done) q_q <= sq_root[30:0];
			ST_MBU:   den_q <= $signed({2'b00, s_q}) + bu2;
			ST_NUM: begin
				n1_q <= bu2 + $signed({3'b000, q_q});
				n2_q <= bu2 - $signed({3'b000, q_q});
			end
			ST_AT1_W: if (co_done) inner_new_q <= round_q32($signed({co_z, 1'b0}));
			ST_AT2_W: if (co_done) outer_new_q <= round_q32($signed({co_z, 1'b0}));
			ST_YAW: begin
				if (x_q == '0 && y_q != '0) begin
					yaw_new_q <= y_q[COORD_W-1] ? (ANGLE_W'(180) <<< FRAC) : '0;
				end else if (y_q == '0 && x_q != '0) begin
					yaw_new_q <= x_q[COORD_W-1] ? -(ANGLE_W'(90) <<< FRAC)
					                            : (ANGLE_W'(90) <<< FRAC);
				end
			end
			ST_YAW_W: if (co_done) yaw_new_q <= round_q32(yaw_t);
			ST_STP_REC: v_q <= v_now;
			ST_STP_FIX: begin
				case (k_q)
					2'd0:    yaw_st_q   <= YAW_W'(sval);
					2'd1:    inner_st_q <= INNER_W'(sval);
					default: outer_st_q <= OUTER_W'(sval);
				endcase
				k_q <= k_q + 2'd1;
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {3'b000, outer_st_q, inner_st_q, yaw_st_q};
					m_tuser_q <= unr_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/ikin_checker.sv
// Port-level checks for arm_inverse_kinematics_steps, attached by bind.
// Depends on ikin_pkg.
module ikin_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ikin_pkg::M_DATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser
);
	import ikin_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one item in flight: busy straight after an accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while working");

	// out of reach gives zero pitch steps
	a_unr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[60:19] == '0)
		else $error("pitch steps non-zero on unreachable target");

	// a new result only appears at the end of the work on an item
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while idle");

endmodule

bind arm_inverse_kinematics_steps ikin_checker u_ikin_checker (.*);

>>> bench/ikin_checker.sv
// Checker for the arm inverse-kinematics block: watches the target, result and
// register channels, predicts step counts and compares them word by word.
// Depends on ikin_pkg for widths and register indexes.
module ikin_scoreboard (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [ikin_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ikin_pkg::M_DATA_W-1:0]     m_tdata,
	input  logic [0:0]                        m_tuser,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ikin_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ikin_pkg::CFG_W-1:0]        cfg_data,
	output int                                fail_count,
	output int                                steps_pending
);
	import ikin_pkg::*;

	typedef struct packed {
		logic signed [YAW_W-1:0]   yaw;
		logic signed [INNER_W-1:0] inner;
		logic signed [OUTER_W-1:0] outer;
		logic                      unreach;
	} step_word_t;

	localparam longint DEG90_Q32 = 64'sd386547056640;
	localparam longint NORM_LIM64 = 64'sd1 << 40;

	longint atan_lut [32] = '{
		64'sd193273528320, 64'sd114096026022, 64'sd60285206654, 64'sd30601712202,
		64'sd15360239307, 64'sd7687607528, 64'sd3844741815, 64'sd1922488225,
		64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
		64'sd60078978, 64'sd30039489, 64'sd15019745, 64'sd7509872,
		64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
		64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335,
		64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
		64'sd917, 64'sd458, 64'sd229, 64'sd115};

	longint link_mm, offset_mm, shoulder_mm, extra_mm;
	longint yaw_now, inner_now, outer_now;
	step_word_t steps_expected [$];

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// vectoring CORDIC, degrees in Q32; >>> on longint floors like the block
	function automatic longint arctan_q32(longint n, longint d);
		longint x, y, z, nx;
		z = 0;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		if (d == 0) return n > 0 ? DEG90_Q32 : (n < 0 ? -DEG90_Q32 : 0);
		while (mag(n) < NORM_LIM64 && d < NORM_LIM64) begin
			n = n * 2;
			d = d * 2;
		end
		x = d;
		y = n;
		for (int i = 0; i < 32; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_lut[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_lut[i];
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic longint q32_to_angle(longint z);
		longint r;
		r = (mag(z) + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC);
		return z < 0 ? -r : r;
	endfunction

	function automatic longint angle_to_steps(longint diff, longint num, longint den);
		longint q;
		q = (mag(diff) * num) / (den << FRAC);
		return diff < 0 ? -q : q;
	endfunction

	function automatic step_word_t solve_target(logic [S_DATA_W-1:0] w);
		longint x, y, z, yaw, inner, outer, t, rad, u, a, b, s, q, den;
		step_word_t e;
		x = longint'($signed(w[13:0]));
		y = longint'($signed(w[27:14]));
		z = longint'($signed(w[41:28]));
		yaw = yaw_now;
		inner = inner_now;
		outer = outer_now;
		e.unreach = 1'b0;
		if (x == 0 && y == 0) begin
		end else if (x == 0) begin
			yaw = y > 0 ? 0 : (64'sd180 << FRAC);
		end else if (y == 0) begin
			yaw = x > 0 ? (64'sd90 << FRAC) : -(64'sd90 << FRAC);
		end else begin
			if (x > 0 && y > 0) t = arctan_q32(mag(x), mag(y));
			else if (x > 0) t = arctan_q32(mag(y), mag(x)) + DEG90_Q32;
			else if (y > 0) t = -arctan_q32(mag(x), mag(y));
			else t = -arctan_q32(mag(y), mag(x)) - DEG90_Q32;
			yaw = q32_to_angle(t);
		end
		rad = int_root(x * x + y * y);
		u = 16 * link_mm;
		a = rad - 16 * offset_mm;
		b = z - 16 * (shoulder_mm + extra_mm);
		s = a * a + b * b;
		if (s > 4 * u * u) begin
			e.unreach = 1'b1;
		end else begin
			q = int_root(s * (4 * u * u - s));
			den = s + 2 * a * u;
			inner = q32_to_angle(2 * arctan_q32(2 * b * u + q, den));
			outer = q32_to_angle(2 * arctan_q32(2 * b * u - q, den));
		end
		e.yaw = YAW_W'(angle_to_steps(yaw - yaw_now, 6400, 9));
		e.inner = e.unreach ? '0 : INNER_W'(angle_to_steps(inner - inner_now, 6400, 3));
		e.outer = e.unreach ? '0 : OUTER_W'(angle_to_steps(outer_now - outer, 6400, 9));
		yaw_now = yaw;
		inner_now = inner;
		outer_now = outer;
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_word_t e;
		if (!arst_n) begin
			link_mm = 160;
			offset_mm = 59;
			shoulder_mm = 131;
			extra_mm = 0;
			yaw_now = 0;
			inner_now = 64'sd45 << FRAC;
			outer_now = -(64'sd45 << FRAC);
			steps_expected.delete();
			steps_pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINK:     link_mm = cfg_data;
					CFG_OFFSET:   offset_mm = cfg_data;
					CFG_SHOULDER: shoulder_mm = cfg_data;
					CFG_EXTRA:    extra_mm = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) steps_expected.push_back(solve_target(s_tdata));
			if (m_tvalid && m_tready) begin
				if (steps_expected.size() == 0) begin
					report_mismatch("unexpected word", m_tdata[18:0], 0);
				end else begin
					e = steps_expected.pop_front();
					if ($signed(m_tdata[18:0]) != e.yaw)
						report_mismatch("yaw_steps", $signed(m_tdata[18:0]), e.yaw);
					if ($signed(m_tdata[40:19]) != e.inner)
						report_mismatch("inner_steps", $signed(m_tdata[40:19]), e.inner);
					if ($signed(m_tdata[60:41]) != e.outer)
						report_mismatch("outer_steps", $signed(m_tdata[60:41]), e.outer);
					if (m_tuser[0] != e.unreach)
						report_mismatch("unreachable", m_tuser[0], e.unreach);
				end
			end
			steps_pending = steps_expected.size();
		end
	end

endmodule

>>> bench/tb_arm_inverse_kinematics_steps.sv
// Top of the arm inverse-kinematics bench: clock, reset, targets, register writes.
// Depends on ikin_pkg, the block itself and ikin_scoreboard.
module tb_arm_inverse_kinematics_steps;
	import ikin_pkg::*;

	localparam int STALL_LIMIT = 20000;   // idle cycles before giving up
	localparam int DRAIN_CYCLES = 400;    // beyond the longest latency

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   fail_count;
	int                   steps_pending;
	int                   quiet_cycles = 0;
	bit                   calm = 1'b0;     // no idling on either side while set

	always #10 clk = ~clk;

	arm_inverse_kinematics_steps dut (.*);

	ikin_scoreboard u_checker (.*);

	// result side: back-pressure about 12% of the time unless calm
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 12);

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// valid stays high after the handshake; the next call or the caller drops it
	task automatic send_target(int x, int y, int z);
		if (!calm)
			while ($urandom_range(99) < 12) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, 14'(z), 14'(y), 14'(x)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// only while idle: drain expected words, then allow a latency's margin
	task automatic write_reg(cfg_idx_t idx, int val);
		s_tvalid <= 1'b0;
		while (steps_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reachable-ish point near the arm's working region, sometimes on the x = 0 axis or anywhere
	task automatic random_target();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			send_target($signed($urandom_range(6000)) - 3000,
				$signed($urandom_range(6000)) - 3000,
				$signed($urandom_range(6000)) - 1000);
		else if (r < 80)
			send_target(0, $urandom_range(1) ? 0 : $signed($urandom_range(16383)) - 8192,
				$signed($urandom_range(16383)) - 8192);
		else
			send_target($signed($urandom_range(16383)) - 8192,
				$signed($urandom_range(16383)) - 8192,
				$signed($urandom_range(16383)) - 8192);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axes, quadrants, extremes, z axis, out of reach
		send_target(0, 0, 0);
		send_target(0, 3000, 2000);
		send_target(0, -3000, 2000);
		send_target(3000, 0, 2000);
		send_target(-3000, 0, 2000);
		send_target(2000, 2500, 1500);
		send_target(2000, -2500, 1500);
		send_target(-2000, 2500, 1500);
		send_target(-2000, -2500, 1500);
		send_target(8191, 8191, 8191);
		send_target(-8192, -8192, -8192);
		send_target(-8192, 8191, 0);
		send_target(944, 0, 2096);
		send_target(0, 0, -8192);
		send_target(1, 1, 1);
		send_target(-1, -1, -1);

		// zero link: only the exact shoulder point is reachable
		write_reg(CFG_LINK, 0);
		write_reg(CFG_OFFSET, 0);
		write_reg(CFG_SHOULDER, 0);
		write_reg(CFG_EXTRA, 0);
		send_target(0, 0, 0);
		send_target(100, 100, 100);

		write_reg(CFG_LINK, 1023);
		write_reg(CFG_OFFSET, 1023);
		write_reg(CFG_SHOULDER, 1023);
		write_reg(CFG_EXTRA, 1023);
		send_target(5000, -5000, 0);
		write_reg(cfg_idx_t'(8'd200), 5);  // unused index, ignored

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_LINK, 160);
					write_reg(CFG_OFFSET, 59);
					write_reg(CFG_SHOULDER, 131);
					write_reg(CFG_EXTRA, 0);
				end
				1: begin
					write_reg(CFG_LINK, 300);
					write_reg(CFG_OFFSET, 10);
					write_reg(CFG_EXTRA, 40);
				end
				2: write_reg(CFG_LINK, 1);
				3: begin
					write_reg(CFG_LINK, $urandom_range(1023, 100));
					write_reg(CFG_OFFSET, $urandom_range(300));
					write_reg(CFG_SHOULDER, $urandom_range(300));
					write_reg(CFG_EXTRA, $urandom_range(100));
				end
				default: write_reg(CFG_LINK, 200);
			endcase
			calm = (phase == 0);
			for (int i = 0; i < 165; i++) random_target();
			calm = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (steps_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/ikin_pkg.sv
rtl/ikin_mul.sv
rtl/ikin_sqrt.sv
rtl/ikin_cordic.sv
rtl/arm_inverse_kinematics_steps.sv
rtl/ikin_checker.sv
bench/ikin_checker.sv
bench/tb_arm_inverse_kinematics_steps.sv
